// ===== design/tgd_pkg.sv =====
package tgd_pkg;

  localparam int MAX_SIDE    = 8;
  localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = 7;
  localparam int SIDE_W      = 4;
  localparam int POS_W       = $clog2(MAX_SIDE);
  localparam int BYTE_W      = 8;
  localparam int MASK_W      = 64;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  // configuration register indexes
  localparam logic REG_GRID_SIZE = 1'b0;
  localparam logic REG_HOLE_MASK = 1'b1;

  // position of the scan: quarter turn, row and column of the turned grille
  typedef struct packed {
    logic [1:0]       pass;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } scan_pos_t;

endpackage

// ===== design/tgd_ram.sv =====
module tgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/tgd_hole.sv =====
module tgd_hole (
  input  tgd_pkg::scan_pos_t             pos,
  input  logic [tgd_pkg::SIDE_W-1:0]     side,
  input  logic [tgd_pkg::MASK_W-1:0]     mask,
  output logic                           hole
);

  logic [tgd_pkg::POS_W-1:0]  last;
  logic [tgd_pkg::POS_W-1:0]  src_row;
  logic [tgd_pkg::POS_W-1:0]  src_col;
  logic [tgd_pkg::COUNT_W-1:0] src_idx;

  // turning the mask r times equals looking up the unturned mask at the
  // cell that the inverse turn gives
  always_comb begin
    last = tgd_pkg::POS_W'(side - 4'd1);
    unique case (pos.pass)
      2'd0: begin
        src_row = pos.row;
        src_col = pos.col;
      end
      2'd1: begin
        src_row = last - pos.col;
        src_col = pos.row;
      end
      2'd2: begin
        src_row = last - pos.row;
        src_col = last - pos.col;
      end
      default: begin
        src_row = pos.col;
        src_col = last - pos.row;
      end
    endcase
    src_idx = tgd_pkg::COUNT_W'(src_row) * tgd_pkg::COUNT_W'(side)
            + tgd_pkg::COUNT_W'(src_col);
    hole = mask[src_idx[tgd_pkg::ADDR_W-1:0]];
  end

endmodule

// ===== design/turning_grille_decipher.sv =====
// Turning grille decipher.
// Input stream s_*: one ciphertext byte per item in tdata, tlast on the final
// byte of a message. Bytes are stored at one per cycle while s_tready is high.
// After the final byte the block deciphers: four quarter-turn passes over the
// n*n cells, one cell per cycle, then a check step. It then emits n*n
// plaintext bytes in row-major order on m_*, one per cycle while m_tready
// is high, tlast on the last. A bad grille, a wrong message length or a grid
// size outside 1..8 gives a single item with tuser (invalid) set, tdata zero
// and tlast set. s_tready is low from the final byte until the last result
// has been issued to the output register. Each message of n*n bytes is
// loaded, decoded and emitted before the next is taken; the single-cell scan
// loop over the message and plaintext memories sets the decode time.
// The output register holds a result while m_tready is low; the plaintext
// memory read waits for the register to free.
// Configuration (cfg_we, cfg_index, cfg_data) is written while idle:
// index 0 grid size (reset 4), index 1 hole mask (reset 0).
// Reset (rst, synchronous) clears the byte count and the scan position and
// empties the output register.
module turning_grille_decipher (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [tgd_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] cipher_byte
  input  logic                           s_tlast,   // is_final
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [tgd_pkg::BYTE_W-1:0]     m_tdata,   // [7:0] plain_byte
  output logic                           m_tuser,   // [0] invalid
  output logic                           m_tlast,   // end_of_run
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [tgd_pkg::MASK_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_CHECK,
    ST_EMIT,
    ST_FAIL
  } state_t;

  state_t state;

  logic [tgd_pkg::SIDE_W-1:0]  grid_size;
  logic [tgd_pkg::MASK_W-1:0]  hole_mask;

  logic [tgd_pkg::COUNT_W-1:0] count;
  logic [tgd_pkg::COUNT_W-1:0] count_next;
  logic [tgd_pkg::COUNT_W-1:0] rd_idx;
  logic [tgd_pkg::COUNT_W-1:0] cells;
  tgd_pkg::scan_pos_t          pos;
  tgd_pkg::scan_pos_t          pass_pos [4];
  logic [tgd_pkg::ADDR_W-1:0]  cell_idx;
  logic                        fill_pend;
  logic [tgd_pkg::ADDR_W-1:0]  fill_addr;
  logic [tgd_pkg::ADDR_W-1:0]  emit_idx;
  logic                        out_inv;
  logic                        out_last;

  logic                        acc;
  logic [2*tgd_pkg::SIDE_W-1:0] square;
  logic                        side_ok;
  logic                        start_ok;
  logic [3:0]                  pass_hole;
  logic                        hole;
  logic                        prior_hole;
  logic                        take;
  logic                        bad;
  logic [tgd_pkg::POS_W-1:0]   last_pos;
  logic                        all_filled;
  logic                        slot_free;
  logic                        issue;
  logic                        emit_last;
  logic                        msg_we;
  logic                        msg_re;
  logic                        plain_re;
  logic [tgd_pkg::BYTE_W-1:0]  msg_rdata;
  logic [tgd_pkg::BYTE_W-1:0]  plain_rdata;

  assign s_tready = (state == ST_LOAD);
  assign acc      = s_tvalid && s_tready;

  // saturating byte count; bytes past the store depth are dropped
  assign count_next = (count == tgd_pkg::COUNT_MAX) ? count : count + 7'd1;
  assign msg_we     = acc && (count < tgd_pkg::COUNT_W'(tgd_pkg::STORE_DEPTH));

  assign square   = {4'b0, grid_size} * {4'b0, grid_size};
  assign side_ok  = (grid_size != '0) &&
                    (grid_size <= tgd_pkg::SIDE_W'(tgd_pkg::MAX_SIDE));
  assign start_ok = side_ok && ({1'b0, count_next} == square);

  // look the current cell up under every turn; a hole met in an earlier pass
  // means the cell already holds a byte, since a refused hole ends the scan
  always_comb begin
    for (int q = 0; q < 4; q++) begin
      pass_pos[q]      = pos;
      pass_pos[q].pass = 2'(q);
    end
  end

  for (genvar q = 0; q < 4; q++) begin : g_hole
    tgd_hole u_hole (
      .pos  (pass_pos[q]),
      .side (grid_size),
      .mask (hole_mask),
      .hole (pass_hole[q])
    );
  end

  assign hole = pass_hole[pos.pass];

  always_comb begin
    prior_hole = 1'b0;
    for (int q = 0; q < 4; q++) begin
      if (2'(q) < pos.pass) begin
        prior_hole = prior_hole | pass_hole[q];
      end
    end
  end

  // a hole takes the next byte if there is one and its cell is still empty
  assign last_pos = tgd_pkg::POS_W'(grid_size - 4'd1);
  assign take     = hole && (rd_idx < cells) && !prior_hole;
  assign bad      = hole && !take;
  assign msg_re   = (state == ST_SCAN) && take;

  // every byte taken went to a distinct cell, so n*n bytes used fills them all
  assign all_filled = (rd_idx == cells);

  // output register frees when empty or taken this cycle
  assign slot_free = !m_tvalid || m_tready;
  assign issue     = slot_free && ((state == ST_EMIT) || (state == ST_FAIL));
  assign plain_re  = (state == ST_EMIT) && slot_free;
  assign emit_last = ({1'b0, emit_idx} == cells - 7'd1);

  assign m_tdata = out_inv ? '0 : plain_rdata;
  assign m_tuser = out_inv;
  assign m_tlast = out_last;

  tgd_ram #(
    .WIDTH (tgd_pkg::BYTE_W),
    .DEPTH (tgd_pkg::STORE_DEPTH)
  ) u_msg_ram (
    .clk   (clk),
    .we    (msg_we),
    .waddr (count[tgd_pkg::ADDR_W-1:0]),
    .wdata (s_tdata),
    .re    (msg_re),
    .raddr (rd_idx[tgd_pkg::ADDR_W-1:0]),
    .rdata (msg_rdata)
  );

  // plaintext write lands in the cycle after the message read
  tgd_ram #(
    .WIDTH (tgd_pkg::BYTE_W),
    .DEPTH (tgd_pkg::STORE_DEPTH)
  ) u_plain_ram (
    .clk   (clk),
    .we    (fill_pend),
    .waddr (fill_addr),
    .wdata (msg_rdata),
    .re    (plain_re),
    .raddr (emit_idx),
    .rdata (plain_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= 4'd4;
      hole_mask <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tgd_pkg::REG_GRID_SIZE: grid_size <= cfg_data[tgd_pkg::SIDE_W-1:0];
        tgd_pkg::REG_HOLE_MASK: hole_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      rd_idx    <= '0;
      cells     <= '0;
      pos       <= '0;
      cell_idx  <= '0;
      fill_pend <= 1'b0;
      fill_addr <= '0;
      emit_idx  <= '0;
      m_tvalid  <= 1'b0;
      out_inv   <= 1'b0;
      out_last  <= 1'b0;
    end else begin
      fill_pend <= msg_re;
      fill_addr <= cell_idx;
      // raise valid on a new issue, drop the held result once taken
      if (issue) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_LOAD: begin
          if (acc) begin
            count <= s_tlast ? '0 : count_next;
            if (s_tlast) begin
              cells    <= square[tgd_pkg::COUNT_W-1:0];
              rd_idx   <= '0;
              pos      <= '0;
              cell_idx <= '0;
              state    <= start_ok ? ST_SCAN : ST_FAIL;
            end
          end
        end

        ST_SCAN: begin
          if (bad) begin
            state <= ST_FAIL;
          end else begin
            if (take) begin
              rd_idx <= rd_idx + 7'd1;
            end
            // advance row-major over the turned grille, then to the next turn
            if (pos.col == last_pos) begin
              pos.col <= '0;
              if (pos.row == last_pos) begin
                pos.row  <= '0;
                cell_idx <= '0;
                pos.pass <= pos.pass + 2'd1;
                if (pos.pass == 2'd3) begin
                  state <= ST_CHECK;
                end
              end else begin
                pos.row  <= pos.row + 3'd1;
                cell_idx <= cell_idx + 6'd1;
              end
            end else begin
              pos.col  <= pos.col + 3'd1;
              cell_idx <= cell_idx + 6'd1;
            end
          end
        end

        ST_CHECK: begin
          emit_idx <= '0;
          state    <= all_filled ? ST_EMIT : ST_FAIL;
        end

        ST_EMIT: begin
          if (slot_free) begin
            out_inv  <= 1'b0;
            out_last <= emit_last;
            if (emit_last) begin
              state <= ST_LOAD;
            end else begin
              emit_idx <= emit_idx + 6'd1;
            end
          end
        end

        ST_FAIL: begin
          if (slot_free) begin
            out_inv  <= 1'b1;
            out_last <= 1'b1;
            state    <= ST_LOAD;
          end
        end

        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule
